FILE: sv/kwm_pkg.sv
package kwm_pkg;

    localparam int ROM_WORDS = 27;
    localparam int ROM_CHARS = 9;
    localparam int ROM_W     = ROM_CHARS * 8;

    localparam logic [7:0] CHAR_END = 8'h00;

    // one-hot match phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_SKIP  = 3'b010,
        PH_MATCH = 3'b100
    } phase_t;

    // words are left-justified, zero padded to ROM_CHARS characters
    localparam logic [ROM_W-1:0] WORD_ROM [ROM_WORDS] = '{
        {"bimonths", 8'h00},
        {"quarters", 8'h00},
        "halfyears",
        {"seasons", 16'h0000},
        {"AH", 56'h0},
        {"ahours", 24'h0},
        {"AM", 56'h0},
        {"amins", 32'h0},
        {"aminutes", 8'h00},
        {"AS", 56'h0},
        {"asecs", 32'h0},
        {"aseconds", 8'h00},
        {"S", 64'h0},
        {"secs", 40'h0},
        {"seconds", 16'h0000},
        {"M", 64'h0},
        {"mins", 40'h0},
        {"minutes", 16'h0000},
        {"H", 64'h0},
        {"hours", 32'h0},
        {"D", 64'h0},
        {"days", 40'h0},
        {"W", 64'h0},
        {"weeks", 32'h0},
        {"months", 24'h0},
        {"Y", 64'h0},
        {"years", 32'h0}
    };

    // character of word w at position pos; zero past the end or past the table
    function automatic logic [7:0] rom_char(input logic [5:0] w, input logic [3:0] pos);
        logic [6:0] lo;
        logic [7:0] ch;
        lo = 7'((ROM_CHARS - 1 - int'(pos)) * 8);
        ch = 8'h00;
        if ((int'(w) < ROM_WORDS) && (int'(pos) < ROM_CHARS))
        begin
            ch = WORD_ROM[w[4:0]][lo +: 8];
        end
        return ch;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
               ((c >= "0") && (c <= "9"));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) ? (c + 8'd32) : c;
    endfunction

endpackage

FILE: sv/keyword_table_prefix_matcher_unit.sv
// Keyword prefix matcher: text characters come in one beat at a time and are
// matched against a fixed table of unit words.
// Input channel: in_valid / in_stall with text_char and start_req. A beat with
// start_req high drops any match in progress and starts a new one with that
// character. Character zero ends the text.
// Output channel: out_valid / out_stall with found, word_index and consumed.
// At most one result beat per match, sent when no word is left or at end of
// text.
// Config: cfg_write / cfg_data set fold_case; write only while idle.
// Timing: a beat is held in the input register, and the state and result
// registers update from it when it is processed. One character per cycle is
// sustained while out_stall does not hold a result: all words are compared in
// parallel against the input register.
// Reset clears all control state; the block is idle, fold_case is zero.
// When out_stall holds a result, the input register keeps working until it
// holds a beat and the result register is full; then in_stall rises.
module keyword_table_prefix_matcher_unit #(
    parameter int NUM_WORDS    = 27,
    parameter int MAX_WORD_LEN = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_char,
    input  logic        start_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [4:0]  word_index,
    output logic [15:0] consumed
);

    localparam int IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic                 fold_reg;
    logic                 in_valid_reg;
    logic [7:0]           char_reg;
    logic                 start_reg;

    logic [NUM_WORDS-1:0] live_reg,  live_next;
    logic [3:0]           pos_reg,   pos_next;
    logic [IDX_W-1:0]     best_reg,  best_next;
    logic                 bv_reg,    bv_next;
    logic [15:0]          cnt_reg,   cnt_next;
    kwm_pkg::phase_t      phase_reg, phase_next;

    logic                 out_valid_reg;
    logic                 found_reg,   found_next;
    logic [4:0]           index_reg,   index_next;
    logic [15:0]          consumed_reg, consumed_next;

    logic                 proc;
    logic                 emit;
    logic                 accept;

    logic [NUM_WORDS-1:0] eff_live;
    logic [3:0]           eff_pos;
    logic [NUM_WORDS-1:0] cmp_keep;
    logic                 cmp_best_set;
    logic [IDX_W-1:0]     cmp_best_idx;

    assign proc     = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !proc;
    assign accept   = in_valid && !in_stall;

    assign eff_live = start_reg ? '1 : live_reg;
    assign eff_pos  = start_reg ? 4'd0 : pos_reg;

    kwm_compare #(
        .NUM_WORDS    (NUM_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .IDX_W        (IDX_W)
    ) u_compare (
        .text_char (char_reg),
        .pos       (eff_pos),
        .fold      (fold_reg),
        .live      (eff_live),
        .keep      (cmp_keep),
        .best_set  (cmp_best_set),
        .best_idx  (cmp_best_idx)
    );

    always_comb
    begin
        live_next  = eff_live;
        pos_next   = eff_pos;
        best_next  = start_reg ? '0 : best_reg;
        bv_next    = start_reg ? 1'b0 : bv_reg;
        cnt_next   = start_reg ? 16'd0 : cnt_reg;
        phase_next = start_reg ? kwm_pkg::PH_SKIP : phase_reg;
        emit       = 1'b0;
        case (phase_next)
            kwm_pkg::PH_SKIP, kwm_pkg::PH_MATCH:
            begin
                if (char_reg == kwm_pkg::CHAR_END)
                begin
                    emit = 1'b1;
                end
                else if ((phase_next == kwm_pkg::PH_SKIP) && !kwm_pkg::is_alnum(char_reg))
                begin
                    if (cnt_next != 16'hFFFF)
                    begin
                        cnt_next = cnt_next + 16'd1;
                    end
                end
                else
                begin
                    phase_next = kwm_pkg::PH_MATCH;
                    live_next  = cmp_keep;
                    if (cmp_best_set)
                    begin
                        best_next = cmp_best_idx;
                        bv_next   = 1'b1;
                    end
                    if (cmp_keep == '0)
                    begin
                        // killing character is not counted
                        emit = 1'b1;
                    end
                    else
                    begin
                        if (cnt_next != 16'hFFFF)
                        begin
                            cnt_next = cnt_next + 16'd1;
                        end
                        if (pos_next != 4'hF)
                        begin
                            pos_next = pos_next + 4'd1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = kwm_pkg::PH_IDLE;
            end
        endcase
        if (emit)
        begin
            phase_next = kwm_pkg::PH_IDLE;
            live_next  = '0;
        end
        found_next    = bv_next;
        index_next    = bv_next ? 5'(best_next) : 5'd0;
        consumed_next = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            live_reg      <= '0;
            pos_reg       <= 4'd0;
            best_reg      <= '0;
            bv_reg        <= 1'b0;
            cnt_reg       <= 16'd0;
            phase_reg     <= kwm_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                fold_reg <= cfg_data;
            end
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                live_reg  <= live_next;
                pos_reg   <= pos_next;
                best_reg  <= best_next;
                bv_reg    <= bv_next;
                cnt_reg   <= cnt_next;
                phase_reg <= phase_next;
            end
            if (proc && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg  <= text_char;
            start_reg <= start_req;
        end
        if (proc && emit)
        begin
            found_reg    <= found_next;
            index_reg    <= index_next;
            consumed_reg <= consumed_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign word_index = index_reg;
    assign consumed   = consumed_reg;

endmodule

FILE: sv/kwm_compare.sv
module kwm_compare #(
    parameter int NUM_WORDS    = 27,
    parameter int MAX_WORD_LEN = 9,
    parameter int IDX_W        = 5
) (
    input  logic [7:0]           text_char,
    input  logic [3:0]           pos,
    input  logic                 fold,
    input  logic [NUM_WORDS-1:0] live,
    output logic [NUM_WORDS-1:0] keep,
    output logic                 best_set,
    output logic [IDX_W-1:0]     best_idx
);

    logic [7:0]           lc;
    logic [NUM_WORDS-1:0] hit;
    logic [NUM_WORDS-1:0] ended;
    logic                 pos_over;

    assign lc       = kwm_pkg::to_lower(text_char);
    assign pos_over = {1'b0, pos} >= 5'(MAX_WORD_LEN);

    for (genvar i = 0; i < NUM_WORDS; i++)
    begin : g_lane
        logic [7:0] w;
        assign w        = kwm_pkg::rom_char(6'(i), pos);
        assign ended[i] = (w == kwm_pkg::CHAR_END) || pos_over;
        assign hit[i]   = !ended[i] && ((text_char == w) || (fold && (lc == w)));
    end

    assign keep = live & hit;

    // best: highest surviving word; if none survives and the highest live
    // word has just ended, that word wins
    always_comb
    begin
        logic             any_keep;
        logic             any_live;
        logic             top_ended;
        logic [IDX_W-1:0] keep_idx;
        logic [IDX_W-1:0] live_idx;
        any_keep  = 1'b0;
        any_live  = 1'b0;
        top_ended = 1'b0;
        keep_idx  = '0;
        live_idx  = '0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if (keep[i])
            begin
                any_keep = 1'b1;
                keep_idx = IDX_W'(i);
            end
            if (live[i])
            begin
                any_live  = 1'b1;
                live_idx  = IDX_W'(i);
                top_ended = ended[i];
            end
        end
        best_set = any_keep || (any_live && top_ended);
        best_idx = any_keep ? keep_idx : live_idx;
    end

endmodule
